/* rtl/core/maze_backtracker_step_top_macros.svh */
// Assertion helpers for the maze backtracker checker.
// Both sample on clk and are disabled while rst is high.
`ifndef MAZE_BACKTRACKER_STEP_TOP_MACROS_SVH
`define MAZE_BACKTRACKER_STEP_TOP_MACROS_SVH

`define MBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mbs_pkg.sv */
`timescale 1ns / 1ps
package mbs_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int RD_W      = ROW_W + 1;
  localparam int CD_W      = COL_W + 1;
  localparam int POS_W     = ROW_W + COL_W;
  localparam int STACK_CAP = MAX_ROWS * MAX_COLS + 1;
  localparam int SADDR_W   = $clog2(STACK_CAP);
  localparam int CNT_W     = $clog2(STACK_CAP + 1);
  localparam int CFG_W     = 7;
  localparam int GRID_W    = 8;
  localparam int PC_W      = 5;

  localparam logic REG_CELL_ROWS = 1'b0;
  localparam logic REG_CELL_COLS = 1'b1;

  typedef enum logic [2:0] {
    KIND_STARTED,
    KIND_CARVED,
    KIND_BACKTRACK,
    KIND_OPENING,
    KIND_IDLE,
    KIND_BAD
  } kind_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT
  } dir_t;

  typedef enum logic [4:0] {
    M_NOP,
    M_TAKE,
    M_CLR_INIT,
    M_CLR_ROW,
    M_START,
    M_SET_BAD,
    M_SET_IDLE,
    M_RD_UP,
    M_RD_CUR,
    M_RD_DN,
    M_EVAL,
    M_CARVE,
    M_POP_RD,
    M_POP,
    M_OPEN1,
    M_OPEN2,
    M_EMIT
  } mop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_STEP,
    C_BAD_START,
    C_CLR_MORE,
    C_IDLE_PHASE,
    C_NONE_FREE,
    C_STACK_EMPTY
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    mop_t  op;
    cond_t cond;
    pc_t   target;
  } ctl_word_t;

  localparam pc_t PC_IDLE     = pc_t'(0);
  localparam pc_t PC_CLR      = pc_t'(4);
  localparam pc_t PC_BAD      = pc_t'(7);
  localparam pc_t PC_EMIT_ONE = pc_t'(8);
  localparam pc_t PC_STEP     = pc_t'(9);
  localparam pc_t PC_BACK     = pc_t'(17);
  localparam pc_t PC_OPEN     = pc_t'(21);

  function automatic ctl_word_t ucode(input pc_t pc);
    ctl_word_t w;
    unique case (pc)
      pc_t'(0):  w = '{M_TAKE,     C_NO_ITEM,     PC_IDLE};
      pc_t'(1):  w = '{M_NOP,      C_IS_STEP,     PC_STEP};
      pc_t'(2):  w = '{M_NOP,      C_BAD_START,   PC_BAD};
      pc_t'(3):  w = '{M_CLR_INIT, C_NEVER,       PC_IDLE};
      pc_t'(4):  w = '{M_CLR_ROW,  C_CLR_MORE,    PC_CLR};
      pc_t'(5):  w = '{M_START,    C_NEVER,       PC_IDLE};
      pc_t'(6):  w = '{M_EMIT,     C_ALWAYS,      PC_IDLE};
      pc_t'(7):  w = '{M_SET_BAD,  C_NEVER,       PC_IDLE};
      pc_t'(8):  w = '{M_EMIT,     C_ALWAYS,      PC_IDLE};
      pc_t'(9):  w = '{M_SET_IDLE, C_IDLE_PHASE,  PC_EMIT_ONE};
      pc_t'(10): w = '{M_RD_UP,    C_NEVER,       PC_IDLE};
      pc_t'(11): w = '{M_RD_CUR,   C_NEVER,       PC_IDLE};
      pc_t'(12): w = '{M_RD_DN,    C_NEVER,       PC_IDLE};
      pc_t'(13): w = '{M_EVAL,     C_NEVER,       PC_IDLE};
      pc_t'(14): w = '{M_NOP,      C_NONE_FREE,   PC_BACK};
      pc_t'(15): w = '{M_CARVE,    C_NEVER,       PC_IDLE};
      pc_t'(16): w = '{M_EMIT,     C_ALWAYS,      PC_IDLE};
      pc_t'(17): w = '{M_NOP,      C_STACK_EMPTY, PC_OPEN};
      pc_t'(18): w = '{M_POP_RD,   C_NEVER,       PC_IDLE};
      pc_t'(19): w = '{M_POP,      C_NEVER,       PC_IDLE};
      pc_t'(20): w = '{M_EMIT,     C_ALWAYS,      PC_IDLE};
      pc_t'(21): w = '{M_OPEN1,    C_NEVER,       PC_IDLE};
      pc_t'(22): w = '{M_EMIT,     C_NEVER,       PC_IDLE};
      pc_t'(23): w = '{M_OPEN2,    C_NEVER,       PC_IDLE};
      pc_t'(24): w = '{M_EMIT,     C_ALWAYS,      PC_IDLE};
      default:   w = '{M_NOP,      C_ALWAYS,      PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [2:0] count_free(input logic [3:0] mask);
    return 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
  endfunction

  // Remainder of a byte by a free-neighbor count of one to four.
  function automatic logic [1:0] mod_small(input logic [7:0] v, input logic [2:0] n);
    logic [3:0] s;
    logic [2:0] t;
    logic [1:0] r;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    case (n)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = (t >= 3'd6) ? 2'd0 : (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic dir_t pick_dir(input logic [3:0] mask, input logic [1:0] pick);
    logic [2:0] seen;
    logic       found;
    dir_t       d;
    seen  = '0;
    found = 1'b0;
    d     = DIR_UP;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && !found) begin
        if (seen == {1'b0, pick}) begin
          d     = dir_t'(2'(i));
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

/* rtl/core/maze_backtracker_step_top.sv */
`timescale 1ns / 1ps
// A start whose cell is in range sweeps all 64 rows of the visited memory one row per cycle.
// The next beat is accepted in the cycle after the last result is loaded.
// Synchronous reset clears the sequencer, the stack count and the position, and sets
// both configuration registers to 8; the visited memory is swept by every in-range start instead.
module maze_backtracker_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [5:0]  start_row,
  input  logic [5:0]  start_col,
  input  logic [7:0]  random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  wall_row,
  output logic [7:0]  wall_col,
  output logic        last
);

  localparam int ROW_W  = mbs_pkg::ROW_W;
  localparam int COL_W  = mbs_pkg::COL_W;
  localparam int RD_W   = mbs_pkg::RD_W;
  localparam int CD_W   = mbs_pkg::CD_W;
  localparam int POS_W  = mbs_pkg::POS_W;
  localparam int CNT_W  = mbs_pkg::CNT_W;
  localparam int SADDR_W = mbs_pkg::SADDR_W;
  localparam int GRID_W = mbs_pkg::GRID_W;
  localparam int CMP_R  = (RD_W > 7) ? RD_W : 7;
  localparam int CMP_C  = (CD_W > 7) ? CD_W : 7;

  logic [mbs_pkg::CFG_W-1:0] cell_rows;
  logic [mbs_pkg::CFG_W-1:0] cell_cols;
  logic [RD_W-1:0]           rows;
  logic [CD_W-1:0]           cols;

  mbs_pkg::pc_t       pc;
  mbs_pkg::pc_t       pc_next;
  mbs_pkg::ctl_word_t ctl;
  logic               cond_hit;
  logic               emit_hold;
  logic               load_out;

  logic                   req_func;
  logic [5:0]             req_row;
  logic [5:0]             req_col;
  logic [7:0]             req_rnd;
  logic [ROW_W-1:0]       clr_addr;
  logic [ROW_W-1:0]       cur_row;
  logic [COL_W-1:0]       cur_col;
  logic [CNT_W-1:0]       stack_count;
  logic                   run_phase;
  logic [mbs_pkg::MAX_COLS-1:0] up_row;
  logic [mbs_pkg::MAX_COLS-1:0] mid_row;
  logic [mbs_pkg::MAX_COLS-1:0] dn_row;
  logic [3:0]             vmask;
  logic [3:0]             vmask_next;
  mbs_pkg::kind_t         res_kind;
  logic [GRID_W-1:0]      res_row;
  logic [GRID_W-1:0]      res_col;
  logic                   res_last;

  logic [mbs_pkg::MAX_COLS-1:0] vis_mem [mbs_pkg::MAX_ROWS];
  logic [mbs_pkg::MAX_COLS-1:0] vis_rdata;
  logic [mbs_pkg::MAX_COLS-1:0] vis_wdata;
  logic [ROW_W-1:0]             vis_raddr;
  logic [ROW_W-1:0]             vis_waddr;
  logic                         vis_we;

  logic [POS_W-1:0]   stk_mem [mbs_pkg::STACK_CAP];
  logic [POS_W-1:0]   stk_rdata;
  logic [POS_W-1:0]   stk_wdata;
  logic [SADDR_W-1:0] stk_waddr;
  logic [SADDR_W-1:0] stk_raddr;
  logic [CNT_W-1:0]   stack_dec;
  logic               stk_we;
  logic               stack_room;

  logic [RD_W-1:0]    row_p1;
  logic [CD_W-1:0]    col_p1;
  logic [ROW_W-1:0]   row_m1;
  logic [COL_W-1:0]   col_m1;
  logic               cur_r_ok;
  logic               cur_c_ok;
  logic [2:0]         free_cnt;
  logic [1:0]         pick;
  mbs_pkg::dir_t      dir;
  logic [ROW_W-1:0]   new_row;
  logic [COL_W-1:0]   new_col;
  logic [GRID_W-1:0]  carve_row;
  logic [GRID_W-1:0]  carve_col;
  logic [mbs_pkg::MAX_COLS-1:0] sel_row;
  logic [mbs_pkg::MAX_COLS-1:0] one_col;

  always_comb begin
    if (cell_rows == '0) begin
      rows = RD_W'(1);
    end else if (int'(cell_rows) > mbs_pkg::MAX_ROWS) begin
      rows = RD_W'(mbs_pkg::MAX_ROWS);
    end else begin
      rows = RD_W'(cell_rows);
    end
    if (cell_cols == '0) begin
      cols = CD_W'(1);
    end else if (int'(cell_cols) > mbs_pkg::MAX_COLS) begin
      cols = CD_W'(mbs_pkg::MAX_COLS);
    end else begin
      cols = CD_W'(cell_cols);
    end
  end

  assign ctl      = mbs_pkg::ucode(pc);
  assign in_stall = (pc != mbs_pkg::PC_IDLE);

  always_comb begin
    case (ctl.cond)
      mbs_pkg::C_ALWAYS:      cond_hit = 1'b1;
      mbs_pkg::C_NO_ITEM:     cond_hit = !in_valid;
      mbs_pkg::C_IS_STEP:     cond_hit = req_func;
      mbs_pkg::C_BAD_START:   cond_hit = (CMP_R'(req_row) >= CMP_R'(rows)) ||
                                         (CMP_C'(req_col) >= CMP_C'(cols));
      mbs_pkg::C_CLR_MORE:    cond_hit = (clr_addr != ROW_W'(mbs_pkg::MAX_ROWS - 1));
      mbs_pkg::C_IDLE_PHASE:  cond_hit = !run_phase;
      mbs_pkg::C_NONE_FREE:   cond_hit = (vmask == 4'd0);
      mbs_pkg::C_STACK_EMPTY: cond_hit = (stack_count == '0);
      default:                cond_hit = 1'b0;
    endcase
  end

  assign emit_hold = (ctl.op == mbs_pkg::M_EMIT) && out_valid && out_stall;
  assign load_out  = (ctl.op == mbs_pkg::M_EMIT) && !emit_hold;

  always_comb begin
    if (emit_hold) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = ctl.target;
    end else begin
      pc_next = mbs_pkg::pc_t'(pc + 1'b1);
    end
  end

  assign row_p1   = RD_W'(cur_row) + RD_W'(1);
  assign col_p1   = CD_W'(cur_col) + CD_W'(1);
  assign row_m1   = cur_row - ROW_W'(1);
  assign col_m1   = cur_col - COL_W'(1);
  assign cur_r_ok = (RD_W'(cur_row) < rows);
  assign cur_c_ok = (CD_W'(cur_col) < cols);

  always_comb begin
    vmask_next[mbs_pkg::DIR_UP]    = (cur_row != '0) && (RD_W'(row_m1) < rows) &&
                                     cur_c_ok && !up_row[cur_col];
    vmask_next[mbs_pkg::DIR_RIGHT] = cur_r_ok && (col_p1 < cols) &&
                                     !mid_row[col_p1[COL_W-1:0]];
    vmask_next[mbs_pkg::DIR_DOWN]  = (row_p1 < rows) && cur_c_ok && !vis_rdata[cur_col];
    vmask_next[mbs_pkg::DIR_LEFT]  = (cur_col != '0) && (CD_W'(col_m1) < cols) &&
                                     cur_r_ok && !mid_row[col_m1];
  end

  assign free_cnt = mbs_pkg::count_free(vmask);
  assign pick     = mbs_pkg::mod_small(req_rnd, free_cnt);
  assign dir      = mbs_pkg::pick_dir(vmask, pick);

  always_comb begin
    new_row   = cur_row;
    new_col   = cur_col;
    carve_row = GRID_W'({cur_row, 1'b1});
    carve_col = GRID_W'({cur_col, 1'b1});
    sel_row   = mid_row;
    unique case (dir)
      mbs_pkg::DIR_UP: begin
        new_row   = row_m1;
        carve_row = GRID_W'({cur_row, 1'b0});
        sel_row   = up_row;
      end
      mbs_pkg::DIR_RIGHT: begin
        new_col   = col_p1[COL_W-1:0];
        carve_col = GRID_W'({col_p1, 1'b0});
      end
      mbs_pkg::DIR_DOWN: begin
        new_row   = row_p1[ROW_W-1:0];
        carve_row = GRID_W'({row_p1, 1'b0});
        sel_row   = dn_row;
      end
      mbs_pkg::DIR_LEFT: begin
        new_col   = col_m1;
        carve_col = GRID_W'({cur_col, 1'b0});
      end
      default: begin
        new_row = cur_row;
      end
    endcase
  end

  assign stack_room = (int'(stack_count) < mbs_pkg::STACK_CAP);
  assign stack_dec  = stack_count - CNT_W'(1);
  assign stk_raddr  = stack_dec[SADDR_W-1:0];

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr;
    vis_wdata = '0;
    one_col   = '0;
    stk_we    = 1'b0;
    stk_waddr = stack_count[SADDR_W-1:0];
    stk_wdata = {cur_row, cur_col};
    case (ctl.op)
      mbs_pkg::M_CLR_ROW: begin
        vis_we = 1'b1;
      end
      mbs_pkg::M_START: begin
        one_col   = '0;
        one_col[COL_W'(req_col)] = 1'b1;
        vis_we    = 1'b1;
        vis_waddr = ROW_W'(req_row);
        vis_wdata = one_col;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {ROW_W'(req_row), COL_W'(req_col)};
      end
      mbs_pkg::M_CARVE: begin
        one_col[new_col] = 1'b1;
        vis_we    = 1'b1;
        vis_waddr = new_row;
        vis_wdata = sel_row | one_col;
        stk_we    = stack_room;
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl.op)
      mbs_pkg::M_RD_UP: vis_raddr = row_m1;
      mbs_pkg::M_RD_DN: vis_raddr = row_p1[ROW_W-1:0];
      default:          vis_raddr = cur_row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= mbs_pkg::PC_IDLE;
      run_phase   <= 1'b0;
      stack_count <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      cell_rows   <= 7'd8;
      cell_cols   <= 7'd8;
      out_valid   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          mbs_pkg::REG_CELL_ROWS: cell_rows <= cfg_data;
          mbs_pkg::REG_CELL_COLS: cell_cols <= cfg_data;
          default:                cell_rows <= cell_rows;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctl.op)
        mbs_pkg::M_START: begin
          cur_row     <= ROW_W'(req_row);
          cur_col     <= COL_W'(req_col);
          stack_count <= CNT_W'(1);
          run_phase   <= 1'b1;
        end
        mbs_pkg::M_CARVE: begin
          if (stack_room) begin
            stack_count <= stack_count + CNT_W'(1);
          end
          cur_row <= new_row;
          cur_col <= new_col;
        end
        mbs_pkg::M_POP_RD: begin
          stack_count <= stack_dec;
        end
        mbs_pkg::M_POP: begin
          cur_row <= stk_rdata[POS_W-1:COL_W];
          cur_col <= stk_rdata[COL_W-1:0];
        end
        mbs_pkg::M_OPEN1: begin
          run_phase <= 1'b0;
        end
        default: begin
          run_phase <= run_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      mbs_pkg::M_TAKE: begin
        if (in_valid) begin
          req_func <= func;
          req_row  <= start_row;
          req_col  <= start_col;
          req_rnd  <= random_value;
        end
      end
      mbs_pkg::M_CLR_INIT: clr_addr <= '0;
      mbs_pkg::M_CLR_ROW:  clr_addr <= clr_addr + ROW_W'(1);
      mbs_pkg::M_START: begin
        res_kind <= mbs_pkg::KIND_STARTED;
        res_row  <= GRID_W'({req_row, 1'b1});
        res_col  <= GRID_W'({req_col, 1'b1});
        res_last <= 1'b1;
      end
      mbs_pkg::M_SET_BAD: begin
        res_kind <= mbs_pkg::KIND_BAD;
        res_row  <= '0;
        res_col  <= '0;
        res_last <= 1'b1;
      end
      mbs_pkg::M_SET_IDLE: begin
        res_kind <= mbs_pkg::KIND_IDLE;
        res_row  <= '0;
        res_col  <= '0;
        res_last <= 1'b1;
      end
      mbs_pkg::M_RD_CUR: up_row  <= vis_rdata;
      mbs_pkg::M_RD_DN:  mid_row <= vis_rdata;
      mbs_pkg::M_EVAL: begin
        dn_row <= vis_rdata;
        vmask  <= vmask_next;
      end
      mbs_pkg::M_CARVE: begin
        res_kind <= mbs_pkg::KIND_CARVED;
        res_row  <= carve_row;
        res_col  <= carve_col;
        res_last <= 1'b1;
      end
      mbs_pkg::M_POP: begin
        res_kind <= mbs_pkg::KIND_BACKTRACK;
        res_row  <= GRID_W'({stk_rdata[POS_W-1:COL_W], 1'b1});
        res_col  <= GRID_W'({stk_rdata[COL_W-1:0], 1'b1});
        res_last <= 1'b1;
      end
      mbs_pkg::M_OPEN1: begin
        res_kind <= mbs_pkg::KIND_OPENING;
        res_row  <= '0;
        res_col  <= GRID_W'(1);
        res_last <= 1'b0;
      end
      mbs_pkg::M_OPEN2: begin
        res_kind <= mbs_pkg::KIND_OPENING;
        res_row  <= GRID_W'({rows, 1'b0});
        res_col  <= GRID_W'({cols, 1'b0}) - GRID_W'(1);
        res_last <= 1'b1;
      end
      default: begin
        vmask <= vmask;
      end
    endcase
    if (load_out) begin
      kind     <= res_kind;
      wall_row <= res_row;
      wall_col <= res_col;
      last     <= res_last;
    end
  end

endmodule

/* rtl/core/mbs_checker.sv */
`timescale 1ns / 1ps
`include "maze_backtracker_step_top_macros.svh"
module mbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] wall_row,
  input logic [7:0] wall_col,
  input logic       last
);

  // A waiting result beat keeps its payload.
  `MBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(wall_row) && $stable(wall_col) && $stable(last), "stalled result beat changed")

  `MBS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while an item is in flight")

  // Only the first opening has a follow-up, and the block stays busy until it is out.
  `MBS_ASSERT_NOW(a_first_open, out_valid && !last, (kind == mbs_pkg::KIND_OPENING) && in_stall, "non-final beat is not a pending opening")

  // A carved wall sits between two cells, so exactly one coordinate is even.
  `MBS_ASSERT_NOW(a_wall_parity, out_valid && (kind == mbs_pkg::KIND_CARVED), wall_row[0] != wall_col[0], "carved wall off the wall lattice")

endmodule

bind maze_backtracker_step_top mbs_checker u_mbs_checker (.*);

/* tb/sv/maze_backtracker_step_top_tb.sv */
`timescale 1ns / 1ps
module maze_backtracker_step_top_tb;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;
  localparam int   RANDOM_BEATS = 1750;
  localparam int   DIRECTED_ROWS = 25;
  localparam int   ROW_STEP [4] = '{-1, 0, 1, 0};
  localparam int   COL_STEP [4] = '{0, 1, 0, -1};

  typedef struct packed {
    logic  [2:0] kind;
    logic  [7:0] wall_r;
    logic  [7:0] wall_c;
    logic        last;
  } maze_result_t;

  typedef struct packed {
    bit             set_dims;
    logic     [6:0] rows;
    logic     [6:0] cols;
    logic           f;
    logic     [5:0] sr;
    logic     [5:0] sc;
    logic     [7:0] rnd;
    bit             typed;
    mbs_pkg::kind_t k;
    logic     [7:0] wr;
    logic     [7:0] wc;
  } directed_row_t;

  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_IDLE, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd8, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_BAD, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd0, 6'd8, 8'h00, 1'b1, mbs_pkg::KIND_BAD, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd63, 6'd63, 8'hFF, 1'b1, mbs_pkg::KIND_BAD, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd63, 6'd63, 8'hFF, 1'b1, mbs_pkg::KIND_IDLE, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd7, 6'd7, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd15,
      8'd15},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'hFF, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'hAA, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd1,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h55, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b1, 7'd1, 7'd1, FUNC_START, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd1,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_BACKTRACK, 8'd1,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b0, mbs_pkg::KIND_OPENING, 8'd0,
      8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_IDLE, 8'd0, 8'd0},
    '{1'b1, 7'd0, 7'd0, FUNC_START, 6'd1, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_BAD, 8'd0, 8'd0},
    '{1'b0, 7'd0, 7'd0, FUNC_START, 6'd0, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd1,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h3C, 1'b1, mbs_pkg::KIND_BACKTRACK, 8'd1,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h00, 1'b0, mbs_pkg::KIND_OPENING, 8'd0,
      8'd0},
    '{1'b1, 7'd127, 7'd127, FUNC_START, 6'd63, 6'd63, 8'h00, 1'b1, mbs_pkg::KIND_STARTED,
      8'd127, 8'd127},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h0F, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b1, 7'd64, 7'd64, FUNC_START, 6'd32, 6'd0, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd65,
      8'd1},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'hF0, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0},
    '{1'b1, 7'd1, 7'd64, FUNC_START, 6'd0, 6'd63, 8'h00, 1'b1, mbs_pkg::KIND_STARTED, 8'd1,
      8'd127},
    '{1'b0, 7'd0, 7'd0, FUNC_STEP, 6'd0, 6'd0, 8'h80, 1'b0, mbs_pkg::KIND_CARVED, 8'd0, 8'd0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = mbs_pkg::REG_CELL_ROWS;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = FUNC_STEP;
  logic [5:0] start_row = '0;
  logic [5:0] start_col = '0;
  logic [7:0] random_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] wall_row;
  logic [7:0] wall_col;
  logic       last;

  maze_result_t pending_maze_results[$];
  int mismatch_count = 0;
  int beats_sent = 0;
  int sender_idle_pct = 35;
  int receiver_idle_pct = 77;

  bit          visited [0:mbs_pkg::MAX_ROWS*mbs_pkg::MAX_COLS-1];
  logic [11:0] path_cells [0:mbs_pkg::STACK_CAP-1];
  int          path_depth = 0;
  int          pos_row = 0;
  int          pos_col = 0;
  bit          maze_running = 1'b0;
  logic [6:0]  dim_rows = 7'd8;
  logic [6:0]  dim_cols = 7'd8;

  maze_backtracker_step_top u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .start_row(start_row), .start_col(start_col),
    .random_value(random_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .wall_row(wall_row), .wall_col(wall_col), .last(last)
  );

  always #6 clk = ~clk;

  function automatic int usable_dim(input logic [6:0] v, input int limit);
    if (v == 7'd0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void add_result(input mbs_pkg::kind_t k, input int r, input int c,
                                     input logic l);
    maze_result_t res;
    res.kind   = k;
    res.wall_r = 8'(r);
    res.wall_c = 8'(c);
    res.last   = l;
    pending_maze_results.push_back(res);
  endfunction

  function automatic void carve_model_step(input logic f, input logic [5:0] sr,
                                           input logic [5:0] sc, input logic [7:0] rnd);
    int  rows_n;
    int  cols_n;
    int  nr;
    int  nc;
    int  free_n;
    int  pick;
    int  dir_sel;
    bit  free_dir [4];
    logic [11:0] top_pos;
    rows_n = usable_dim(dim_rows, mbs_pkg::MAX_ROWS);
    cols_n = usable_dim(dim_cols, mbs_pkg::MAX_COLS);
    if (f == FUNC_START) begin
      if (int'(sr) >= rows_n || int'(sc) >= cols_n) begin
        add_result(mbs_pkg::KIND_BAD, 0, 0, 1'b1);
        return;
      end
      foreach (visited[i]) visited[i] = 1'b0;
      pos_row = int'(sr);
      pos_col = int'(sc);
      visited[pos_row * mbs_pkg::MAX_COLS + pos_col] = 1'b1;
      path_cells[0] = {sr, sc};
      path_depth = 1;
      maze_running = 1'b1;
      add_result(mbs_pkg::KIND_STARTED, 2 * pos_row + 1, 2 * pos_col + 1, 1'b1);
      return;
    end
    if (!maze_running) begin
      add_result(mbs_pkg::KIND_IDLE, 0, 0, 1'b1);
      return;
    end
    free_n = 0;
    for (int i = 0; i < 4; i++) begin
      nr = pos_row + ROW_STEP[i];
      nc = pos_col + COL_STEP[i];
      free_dir[i] = (nr >= 0 && nc >= 0 && nr < rows_n && nc < cols_n) &&
                    !visited[nr * mbs_pkg::MAX_COLS + nc];
      if (free_dir[i]) free_n++;
    end
    if (free_n != 0) begin
      pick = int'(rnd) % free_n;
      dir_sel = 0;
      for (int i = 3; i >= 0; i--) begin
        if (free_dir[i]) begin
          free_n--;
          if (free_n == pick) dir_sel = i;
        end
      end
      if (path_depth < mbs_pkg::STACK_CAP) begin
        path_cells[path_depth] = {6'(pos_row), 6'(pos_col)};
        path_depth++;
      end
      add_result(mbs_pkg::KIND_CARVED, 2 * pos_row + 1 + ROW_STEP[dir_sel],
                 2 * pos_col + 1 + COL_STEP[dir_sel], 1'b1);
      pos_row = pos_row + ROW_STEP[dir_sel];
      pos_col = pos_col + COL_STEP[dir_sel];
      visited[pos_row * mbs_pkg::MAX_COLS + pos_col] = 1'b1;
      return;
    end
    if (path_depth != 0) begin
      path_depth--;
      top_pos = path_cells[path_depth];
      pos_row = int'(top_pos[11:6]);
      pos_col = int'(top_pos[5:0]);
      add_result(mbs_pkg::KIND_BACKTRACK, 2 * pos_row + 1, 2 * pos_col + 1, 1'b1);
      return;
    end
    maze_running = 1'b0;
    add_result(mbs_pkg::KIND_OPENING, 0, 1, 1'b0);
    add_result(mbs_pkg::KIND_OPENING, 2 * rows_n, 2 * cols_n - 1, 1'b1);
  endfunction

  task automatic send_beat(input logic f, input logic [5:0] sr, input logic [5:0] sc,
                           input logic [7:0] rnd);
    if (beats_sent >= DIRECTED_ROWS + 2 * RANDOM_BEATS / 3) begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end else if (beats_sent >= DIRECTED_ROWS + RANDOM_BEATS / 3) begin
      sender_idle_pct = 77;
      receiver_idle_pct = 35;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    start_row    <= sr;
    start_col    <= sc;
    random_value <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    carve_model_step(f, sr, sc, rnd);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_maze_results.size() != 0);
  endtask

  task automatic set_dim_reg(input logic idx, input logic [6:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mbs_pkg::REG_CELL_ROWS) dim_rows = v;
    else dim_cols = v;
    @(posedge clk);
  endtask

  task automatic send_noise_beat();
    send_beat(1'($urandom_range(1)), 6'($urandom_range(63)), 6'($urandom_range(63)),
              8'($urandom_range(255)));
  endtask

  task automatic run_maze();
    logic [6:0] rv;
    logic [6:0] cv;
    int rows_n;
    int cols_n;
    int steps;
    int change_at;
    int abort_at;
    wait_for_results();
    case ($urandom_range(19))
      0: begin rv = 7'd0; cv = 7'($urandom_range(1, 6)); end
      1: begin rv = 7'($urandom_range(65, 127)); cv = 7'($urandom_range(0, 2)); end
      2: begin rv = 7'($urandom_range(1, 3)); cv = 7'd64; end
      3: begin rv = 7'($urandom_range(1, 2)); cv = 7'($urandom_range(65, 127)); end
      default: begin rv = 7'($urandom_range(1, 8)); cv = 7'($urandom_range(1, 8)); end
    endcase
    set_dim_reg(mbs_pkg::REG_CELL_ROWS, rv);
    set_dim_reg(mbs_pkg::REG_CELL_COLS, cv);
    rows_n = usable_dim(rv, mbs_pkg::MAX_ROWS);
    cols_n = usable_dim(cv, mbs_pkg::MAX_COLS);
    change_at = ($urandom_range(4) == 0) ? $urandom_range(1, 2 * rows_n * cols_n) : -1;
    abort_at  = ($urandom_range(9) == 0) ? $urandom_range(1, 2 * rows_n * cols_n) : -1;
    send_beat(FUNC_START, 6'($urandom_range(rows_n - 1)), 6'($urandom_range(cols_n - 1)),
              8'($urandom_range(255)));
    steps = 0;
    while (maze_running && steps < 20000 && steps != abort_at &&
           beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      if (steps == change_at) begin
        wait_for_results();
        if ($urandom_range(1)) set_dim_reg(mbs_pkg::REG_CELL_ROWS, 7'($urandom_range(8)));
        set_dim_reg(mbs_pkg::REG_CELL_COLS, 7'($urandom_range(8)));
      end
      if ($urandom_range(39) == 0) send_noise_beat();
      else send_beat(FUNC_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     8'($urandom_range(255)));
      steps++;
    end
    if ($urandom_range(9) < 3)
      send_beat(FUNC_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    maze_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_maze_results.size() == 0) begin
          $display("%0t: unexpected beat kind %0d wall (%0d,%0d) last %0b",
                   $time, kind, wall_row, wall_col, last);
          mismatch_count++;
        end else begin
          want = pending_maze_results.pop_front();
          if (kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
            mismatch_count++;
          end
          if (wall_row !== want.wall_r) begin
            $display("%0t: wall_row expected %0d got %0d", $time, want.wall_r, wall_row);
            mismatch_count++;
          end
          if (wall_col !== want.wall_c) begin
            $display("%0t: wall_col expected %0d got %0d", $time, want.wall_c, wall_col);
            mismatch_count++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, last);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  initial begin
    maze_result_t typed_res;
    foreach (visited[i]) visited[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].set_dims) begin
        wait_for_results();
        set_dim_reg(mbs_pkg::REG_CELL_ROWS, DIRECTED[i].rows);
        set_dim_reg(mbs_pkg::REG_CELL_COLS, DIRECTED[i].cols);
      end
      send_beat(DIRECTED[i].f, DIRECTED[i].sr, DIRECTED[i].sc, DIRECTED[i].rnd);
      if (DIRECTED[i].typed) begin
        typed_res.kind   = DIRECTED[i].k;
        typed_res.wall_r = DIRECTED[i].wr;
        typed_res.wall_c = DIRECTED[i].wc;
        typed_res.last   = 1'b1;
        pending_maze_results[pending_maze_results.size() - 1] = typed_res;
      end
    end
    while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 5)) send_noise_beat();
      end else begin
        run_maze();
      end
    end
    wait_for_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_maze_results.size() == 0) begin
      $display("** maze_backtracker_step_top: PASSED **");
    end else begin
      $display("** maze_backtracker_step_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("** maze_backtracker_step_top: FAILED **");
    $finish;
  end

endmodule
